>>> design/lcdnib_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdnib_pkg
// Shared types, constants and the microcode ROM of the character LCD
// nibble bus sequencer.
// ----------------------------------------------------------------------------
package lcdnib_pkg;

  // Item kinds on the input stream
  typedef enum logic [1:0] {
    OP_CMD  = 2'd0,
    OP_DATA = 2'd1,
    OP_PWR  = 2'd2
  } op_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_PULSE_HOLD   = 2'd0,
    REG_SHORT_SETTLE = 2'd1,
    REG_LONG_SETTLE  = 2'd2,
    REG_PWR_WAIT     = 2'd3
  } reg_idx_e;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [7:0]  RST_PULSE_HOLD   = 8'd2;
  localparam logic [15:0] RST_SHORT_SETTLE = 16'd40;
  localparam logic [15:0] RST_LONG_SETTLE  = 16'd2000;
  localparam logic [15:0] RST_PWR_WAIT     = 16'd15000;

  localparam logic [7:0]  CMD_CLEAR        = 8'h01;
  localparam logic [7:0]  CMD_HOME         = 8'h02;
  localparam logic [7:0]  WAKE_BYTE        = 8'h03;
  localparam logic [7:0]  FOUR_BIT_BYTE    = 8'h02;
  localparam logic [7:0]  CMD_FUNCTION_SET = 8'h28;
  localparam logic [7:0]  CMD_DISPLAY_ON   = 8'h0C;
  localparam logic [7:0]  CMD_ENTRY_MODE   = 8'h06;

  localparam logic [15:0] WAKE_FIRST_US  = 16'd5000;
  localparam logic [15:0] WAKE_NEXT_US   = 16'd150;
  localparam logic [15:0] CLEAR_EXTRA_US = 16'd2000;

  // Nibble source of a step
  typedef enum logic [1:0] {
    NIB_IN_HI = 2'd0,
    NIB_IN_LO = 2'd1,
    NIB_C_HI  = 2'd2,
    NIB_C_LO  = 2'd3
  } nib_sel_e;

  // Hold time source of a step
  typedef enum logic [2:0] {
    HOLD_PULSE     = 3'd0,
    HOLD_SETTLE_IN = 3'd1,
    HOLD_SETTLE_C  = 3'd2,
    HOLD_PWR_WAIT  = 3'd3,
    HOLD_WAKE1     = 3'd4,
    HOLD_WAKEN     = 3'd5,
    HOLD_CLR_EXTRA = 3'd6
  } hold_sel_e;

  // One control word of the program
  typedef struct packed {
    logic       en;
    nib_sel_e   nib_sel;
    hold_sel_e  hold_sel;
    logic [7:0] cbyte;
    logic       last;
  } ucode_t;

  // Sequencer to datapath
  typedef struct packed {
    logic       busy;
    ucode_t     cw;
    logic       rs;
    logic [7:0] item_byte;
  } step_t;

  typedef struct packed {
    logic [7:0]  pulse_hold;
    logic [15:0] short_settle;
    logic [15:0] long_settle;
    logic [15:0] pwr_wait;
  } cfg_t;

  // One bus phase
  typedef struct packed {
    logic [15:0] hold_us;
    logic [3:0]  bus_nibble;
    logic        enable_level;
    logic        read_write;
    logic        reg_select;
    logic        last;
  } phase_t;

  localparam int unsigned UCODE_DEPTH = 39;
  localparam int unsigned PC_W        = $clog2(UCODE_DEPTH);

  localparam logic [PC_W-1:0] START_BYTE = PC_W'(0);
  localparam logic [PC_W-1:0] START_PWR  = PC_W'(5);

  function automatic ucode_t uw(logic en, nib_sel_e ns, hold_sel_e hs,
                                logic [7:0] cb, logic last);
    ucode_t w;
    w.en       = en;
    w.nib_sel  = ns;
    w.hold_sel = hs;
    w.cbyte    = cb;
    w.last     = last;
    return w;
  endfunction

  function automatic ucode_t ucode_rom(logic [PC_W-1:0] addr);
    ucode_t w;
    case (addr)
      // byte write of the item byte
      6'd0:  w = uw(1'b1, NIB_IN_HI, HOLD_PULSE,     8'h00, 1'b0);
      6'd1:  w = uw(1'b0, NIB_IN_HI, HOLD_PULSE,     8'h00, 1'b0);
      6'd2:  w = uw(1'b1, NIB_IN_LO, HOLD_PULSE,     8'h00, 1'b0);
      6'd3:  w = uw(1'b0, NIB_IN_LO, HOLD_PULSE,     8'h00, 1'b0);
      6'd4:  w = uw(1'b0, NIB_IN_LO, HOLD_SETTLE_IN, 8'h00, 1'b1);
      // power-up: initial wait and wake-up nibbles
      6'd5:  w = uw(1'b0, NIB_C_LO, HOLD_PWR_WAIT,   8'h00, 1'b0);
      6'd6:  w = uw(1'b1, NIB_C_LO, HOLD_PULSE,      WAKE_BYTE, 1'b0);
      6'd7:  w = uw(1'b0, NIB_C_LO, HOLD_PULSE,      WAKE_BYTE, 1'b0);
      6'd8:  w = uw(1'b0, NIB_C_LO, HOLD_WAKE1,      WAKE_BYTE, 1'b0);
      6'd9:  w = uw(1'b1, NIB_C_LO, HOLD_PULSE,      WAKE_BYTE, 1'b0);
      6'd10: w = uw(1'b0, NIB_C_LO, HOLD_PULSE,      WAKE_BYTE, 1'b0);
      6'd11: w = uw(1'b0, NIB_C_LO, HOLD_WAKEN,      WAKE_BYTE, 1'b0);
      6'd12: w = uw(1'b1, NIB_C_LO, HOLD_PULSE,      WAKE_BYTE, 1'b0);
      6'd13: w = uw(1'b0, NIB_C_LO, HOLD_PULSE,      WAKE_BYTE, 1'b0);
      6'd14: w = uw(1'b0, NIB_C_LO, HOLD_WAKEN,      WAKE_BYTE, 1'b0);
      6'd15: w = uw(1'b1, NIB_C_LO, HOLD_PULSE,      FOUR_BIT_BYTE, 1'b0);
      6'd16: w = uw(1'b0, NIB_C_LO, HOLD_PULSE,      FOUR_BIT_BYTE, 1'b0);
      6'd17: w = uw(1'b0, NIB_C_LO, HOLD_WAKEN,      FOUR_BIT_BYTE, 1'b0);
      // function set
      6'd18: w = uw(1'b1, NIB_C_HI, HOLD_PULSE,      CMD_FUNCTION_SET, 1'b0);
      6'd19: w = uw(1'b0, NIB_C_HI, HOLD_PULSE,      CMD_FUNCTION_SET, 1'b0);
      6'd20: w = uw(1'b1, NIB_C_LO, HOLD_PULSE,      CMD_FUNCTION_SET, 1'b0);
      6'd21: w = uw(1'b0, NIB_C_LO, HOLD_PULSE,      CMD_FUNCTION_SET, 1'b0);
      6'd22: w = uw(1'b0, NIB_C_LO, HOLD_SETTLE_C,   CMD_FUNCTION_SET, 1'b0);
      // display on
      6'd23: w = uw(1'b1, NIB_C_HI, HOLD_PULSE,      CMD_DISPLAY_ON, 1'b0);
      6'd24: w = uw(1'b0, NIB_C_HI, HOLD_PULSE,      CMD_DISPLAY_ON, 1'b0);
      6'd25: w = uw(1'b1, NIB_C_LO, HOLD_PULSE,      CMD_DISPLAY_ON, 1'b0);
      6'd26: w = uw(1'b0, NIB_C_LO, HOLD_PULSE,      CMD_DISPLAY_ON, 1'b0);
      6'd27: w = uw(1'b0, NIB_C_LO, HOLD_SETTLE_C,   CMD_DISPLAY_ON, 1'b0);
      // clear, then an extra wait
      6'd28: w = uw(1'b1, NIB_C_HI, HOLD_PULSE,      CMD_CLEAR, 1'b0);
      6'd29: w = uw(1'b0, NIB_C_HI, HOLD_PULSE,      CMD_CLEAR, 1'b0);
      6'd30: w = uw(1'b1, NIB_C_LO, HOLD_PULSE,      CMD_CLEAR, 1'b0);
      6'd31: w = uw(1'b0, NIB_C_LO, HOLD_PULSE,      CMD_CLEAR, 1'b0);
      6'd32: w = uw(1'b0, NIB_C_LO, HOLD_SETTLE_C,   CMD_CLEAR, 1'b0);
      6'd33: w = uw(1'b0, NIB_C_LO, HOLD_CLR_EXTRA,  CMD_CLEAR, 1'b0);
      // entry mode
      6'd34: w = uw(1'b1, NIB_C_HI, HOLD_PULSE,      CMD_ENTRY_MODE, 1'b0);
      6'd35: w = uw(1'b0, NIB_C_HI, HOLD_PULSE,      CMD_ENTRY_MODE, 1'b0);
      6'd36: w = uw(1'b1, NIB_C_LO, HOLD_PULSE,      CMD_ENTRY_MODE, 1'b0);
      6'd37: w = uw(1'b0, NIB_C_LO, HOLD_PULSE,      CMD_ENTRY_MODE, 1'b0);
      6'd38: w = uw(1'b0, NIB_C_LO, HOLD_SETTLE_C,   CMD_ENTRY_MODE, 1'b1);
      default: w = uw(1'b0, NIB_C_LO, HOLD_PULSE,    8'h00, 1'b1);
    endcase
    return w;
  endfunction

endpackage

>>> design/lcdnib_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdnib_cfg_regs
// Timing registers, written through a plain indexed write port.
// ----------------------------------------------------------------------------
module lcdnib_cfg_regs import lcdnib_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  we_i,
  input  logic [CFG_IDX_W-1:0]  index_i,
  input  logic [CFG_DATA_W-1:0] wdata_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      unique case (reg_idx_e'(index_i))
        REG_PULSE_HOLD:   cfg_d.pulse_hold   = wdata_i[7:0];
        REG_SHORT_SETTLE: cfg_d.short_settle = wdata_i;
        REG_LONG_SETTLE:  cfg_d.long_settle  = wdata_i;
        REG_PWR_WAIT:     cfg_d.pwr_wait     = wdata_i;
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pulse_hold   <= RST_PULSE_HOLD;
      cfg_q.short_settle <= RST_SHORT_SETTLE;
      cfg_q.long_settle  <= RST_LONG_SETTLE;
      cfg_q.pwr_wait     <= RST_PWR_WAIT;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> design/lcdnib_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdnib_sequencer
// Step counter over the microcode ROM: picks the entry point from the item
// kind, advances one step per phase and stops on the step marked last.
// ----------------------------------------------------------------------------
module lcdnib_sequencer import lcdnib_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic [1:0] op_i,
  input  logic [7:0] byte_i,
  input  logic       adv_i,
  output logic       ready_o,
  output step_t      step_o
);

  logic            busy_q, busy_d;
  logic [PC_W-1:0] pc_q, pc_d;
  logic [7:0]      byte_q, byte_d;
  logic            rs_q, rs_d;
  ucode_t          cw;

  assign cw = ucode_rom(pc_q);

  // Take the next item while the final step is being handed on
  assign ready_o = !busy_q || (adv_i && cw.last);

  always_comb begin
    busy_d = busy_q;
    pc_d   = pc_q;
    byte_d = byte_q;
    rs_d   = rs_q;
    if (busy_q && adv_i) begin
      if (cw.last) begin
        busy_d = 1'b0;
      end else begin
        pc_d = pc_q + PC_W'(1);
      end
    end
    if (start_i) begin
      byte_d = byte_i;
      unique case (op_e'(op_i))
        OP_CMD: begin
          busy_d = 1'b1;
          pc_d   = START_BYTE;
          rs_d   = 1'b0;
        end
        OP_DATA: begin
          busy_d = 1'b1;
          pc_d   = START_BYTE;
          rs_d   = 1'b1;
        end
        OP_PWR: begin
          busy_d = 1'b1;
          pc_d   = START_PWR;
          rs_d   = 1'b0;
        end
        default: busy_d = 1'b0; // unused kind: drop, no phases
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pc_q   <= START_BYTE;
    end else begin
      busy_q <= busy_d;
      pc_q   <= pc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    rs_q   <= rs_d;
  end

  assign step_o.busy      = busy_q;
  assign step_o.cw        = cw;
  assign step_o.rs        = rs_q;
  assign step_o.item_byte = byte_q;

endmodule

>>> design/lcdnib_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdnib_datapath
// Turns one control word into a bus phase: nibble and hold-time selection.
// ----------------------------------------------------------------------------
module lcdnib_datapath import lcdnib_pkg::*; (
  input  step_t  step_i,
  input  cfg_t   cfg_i,
  output phase_t phase_o
);

  logic [7:0] settle_byte;
  logic       long_settle;

  always_comb begin
    settle_byte = (step_i.cw.hold_sel == HOLD_SETTLE_IN) ? step_i.item_byte
                                                         : step_i.cw.cbyte;
    // Clear and home need the long settle, but only as commands
    long_settle = !step_i.rs && (settle_byte == CMD_CLEAR || settle_byte == CMD_HOME);

    phase_o.reg_select   = step_i.rs;
    phase_o.read_write   = 1'b0;
    phase_o.enable_level = step_i.cw.en;
    phase_o.last         = step_i.cw.last;

    unique case (step_i.cw.nib_sel)
      NIB_IN_HI: phase_o.bus_nibble = step_i.item_byte[7:4];
      NIB_IN_LO: phase_o.bus_nibble = step_i.item_byte[3:0];
      NIB_C_HI:  phase_o.bus_nibble = step_i.cw.cbyte[7:4];
      NIB_C_LO:  phase_o.bus_nibble = step_i.cw.cbyte[3:0];
      default:   phase_o.bus_nibble = step_i.cw.cbyte[3:0];
    endcase

    unique case (step_i.cw.hold_sel)
      HOLD_PULSE:     phase_o.hold_us = {8'h00, cfg_i.pulse_hold};
      HOLD_SETTLE_IN,
      HOLD_SETTLE_C:  phase_o.hold_us = long_settle ? cfg_i.long_settle
                                                    : cfg_i.short_settle;
      HOLD_PWR_WAIT:  phase_o.hold_us = cfg_i.pwr_wait;
      HOLD_WAKE1:     phase_o.hold_us = WAKE_FIRST_US;
      HOLD_WAKEN:     phase_o.hold_us = WAKE_NEXT_US;
      HOLD_CLR_EXTRA: phase_o.hold_us = CLEAR_EXTRA_US;
      default:        phase_o.hold_us = {8'h00, cfg_i.pulse_hold};
    endcase
  end

endmodule

>>> design/char_lcd_nibble_bus_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_lcd_nibble_bus_sequencer
// Character LCD 4-bit bus sequencer: bytes and power-up requests in, timed
// bus phases (RS, RW, EN, D7..D4, hold time) out.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis: one item per transfer, tdata = {byte_value, op}. op 0 sends a
//   command byte, op 1 a data byte, op 2 plays the power-up sequence; op 3
//   is taken and produces nothing.
//   m_axis: one bus phase per transfer, tlast on the final phase of an item.
//   cfg: write enable, index and data; write only while the block is idle.
// Sequencing:
//   A byte gives 5 phases, power-up 34. The step counter walks the microcode
//   ROM at one phase per cycle unless the receiver stalls; the next item is
//   taken in the cycle its predecessor's last phase is registered. An input
//   transfer loads the step counter; the output register then takes a phase.
// Reset idles the sequencer, clears the output valid and loads the timing
// registers with their defaults. A stalled receiver holds the output
// register and the step counter; no phase is lost or repeated.
// ----------------------------------------------------------------------------
module char_lcd_nibble_bus_sequencer import lcdnib_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [15:0]           s_axis_tdata,  // [1:0] op, [9:2] byte_value
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [0] reg_select, [1] read_write, [2] enable_level, [6:3] bus_nibble,
  // [22:7] hold_us
  output logic [23:0]           m_axis_tdata,
  output logic                  m_axis_tlast,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  cfg_t   cfg;
  step_t  step;
  phase_t phase;
  phase_t phase_q;
  logic   out_valid_q, out_valid_d;
  logic   adv;
  logic   in_xfer;

  assign adv     = !out_valid_q || m_axis_tready;
  assign in_xfer = s_axis_tvalid && s_axis_tready;

  lcdnib_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_we_i),
    .index_i (cfg_index_i),
    .wdata_i (cfg_wdata_i),
    .cfg_o   (cfg)
  );

  lcdnib_sequencer u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_xfer),
    .op_i    (s_axis_tdata[1:0]),
    .byte_i  (s_axis_tdata[9:2]),
    .adv_i   (adv),
    .ready_o (s_axis_tready),
    .step_o  (step)
  );

  lcdnib_datapath u_dp (
    .step_i  (step),
    .cfg_i   (cfg),
    .phase_o (phase)
  );

  // Output register: load a phase when there is room, drop valid once taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (step.busy && adv) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step.busy && adv) begin
      phase_q <= phase;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, phase_q.hold_us, phase_q.bus_nibble,
                          phase_q.enable_level, phase_q.read_write,
                          phase_q.reg_select};
  assign m_axis_tlast  = phase_q.last;

  // A taken item of a known kind starts the sequencer
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && (s_axis_tdata[1:0] == OP_CMD || s_axis_tdata[1:0] == OP_DATA ||
                 s_axis_tdata[1:0] == OP_PWR)) |=> step.busy)
    else $error("sequencer not started after input transfer");

  // Every run ends with the enable line low
  a_last_en_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |-> !m_axis_tdata[2])
    else $error("final phase with enable high");

  // The bus is only ever written
  a_write_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !m_axis_tdata[1])
    else $error("read phase emitted");

  // No new item while a run is still mid-program
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step.busy && !(adv && step.cw.last)) |-> !s_axis_tready)
    else $error("input taken during a run");

endmodule

>>> verif/tb_char_lcd_nibble_bus_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_char_lcd_nibble_bus_sequencer
// Self-checking bench for the character LCD nibble bus sequencer. Command,
// data, power-up and unused items go in through the input stream under
// several timing settings. An internal predictor expands each accepted item
// into its bus phases. Every phase on the output stream is compared field by
// field with the oldest predicted one. Both streams idle and stall at random.
// ----------------------------------------------------------------------------

import lcdnib_pkg::*;

class bus_phase_scoreboard;

  typedef struct packed {
    logic        rs;
    logic        rw;
    logic        en;
    logic [3:0]  nib;
    logic [15:0] hold;
    logic        last;
  } bus_phase_t;

  bus_phase_t  expected_phases[$];
  logic [7:0]  pulse_hold;
  logic [15:0] settle_short;
  logic [15:0] settle_long;
  logic [15:0] wake_wait;
  int          mismatch_count;

  function new();
    pulse_hold     = RST_PULSE_HOLD;
    settle_short   = RST_SHORT_SETTLE;
    settle_long    = RST_LONG_SETTLE;
    wake_wait      = RST_PWR_WAIT;
    mismatch_count = 0;
  endfunction

  // Register copies; the pulse hold keeps only its low byte
  function void set_timing(logic [15:0] pulse_us, logic [15:0] settle_s_us,
                           logic [15:0] settle_l_us, logic [15:0] wake_wait_us);
    pulse_hold   = pulse_us[7:0];
    settle_short = settle_s_us;
    settle_long  = settle_l_us;
    wake_wait    = wake_wait_us;
  endfunction

  function void add_phase(logic rs, logic en, logic [3:0] nib, logic [15:0] hold_us);
    bus_phase_t ph;
    ph.rs   = rs;
    ph.rw   = 1'b0;
    ph.en   = en;
    ph.nib  = nib;
    ph.hold = hold_us;
    ph.last = 1'b0;
    expected_phases.push_back(ph);
  endfunction

  function void add_strobe(logic rs, logic [3:0] nib);
    add_phase(rs, 1'b1, nib, {8'h00, pulse_hold});
    add_phase(rs, 1'b0, nib, {8'h00, pulse_hold});
  endfunction

  function void add_byte(logic rs, logic [7:0] b);
    logic [15:0] settle;
    settle = settle_short;
    if (!rs && (b == CMD_CLEAR || b == CMD_HOME)) begin
      settle = settle_long;
    end
    add_strobe(rs, b[7:4]);
    add_strobe(rs, b[3:0]);
    add_phase(rs, 1'b0, b[3:0], settle);
  endfunction

  // Expand one accepted item into the bus phases it must produce
  function void note_item(logic [1:0] op, logic [7:0] b);
    bus_phase_t tail;
    int         first_idx;
    first_idx = expected_phases.size();
    case (op)
      OP_CMD: begin
        add_byte(1'b0, b);
      end
      OP_DATA: begin
        add_byte(1'b1, b);
      end
      OP_PWR: begin
        add_phase(1'b0, 1'b0, 4'h0, wake_wait);
        add_strobe(1'b0, WAKE_BYTE[3:0]);
        add_phase(1'b0, 1'b0, WAKE_BYTE[3:0], WAKE_FIRST_US);
        add_strobe(1'b0, WAKE_BYTE[3:0]);
        add_phase(1'b0, 1'b0, WAKE_BYTE[3:0], WAKE_NEXT_US);
        add_strobe(1'b0, WAKE_BYTE[3:0]);
        add_phase(1'b0, 1'b0, WAKE_BYTE[3:0], WAKE_NEXT_US);
        add_strobe(1'b0, FOUR_BIT_BYTE[3:0]);
        add_phase(1'b0, 1'b0, FOUR_BIT_BYTE[3:0], WAKE_NEXT_US);
        add_byte(1'b0, CMD_FUNCTION_SET);
        add_byte(1'b0, CMD_DISPLAY_ON);
        add_byte(1'b0, CMD_CLEAR);
        add_phase(1'b0, 1'b0, CMD_CLEAR[3:0], CLEAR_EXTRA_US);
        add_byte(1'b0, CMD_ENTRY_MODE);
      end
      default: begin
      end
    endcase
    if (expected_phases.size() > first_idx) begin
      tail      = expected_phases[expected_phases.size() - 1];
      tail.last = 1'b1;
      expected_phases[expected_phases.size() - 1] = tail;
    end
  endfunction

  task report_mismatch(string msg);
    mismatch_count++;
    $display("%0t mismatch: %s", $time, msg);
  endtask

  task check_phase(logic [23:0] tdata, logic tlast);
    bus_phase_t got;
    bus_phase_t want;
    got.rs   = tdata[0];
    got.rw   = tdata[1];
    got.en   = tdata[2];
    got.nib  = tdata[6:3];
    got.hold = tdata[22:7];
    got.last = tlast;
    if (expected_phases.size() == 0) begin
      report_mismatch($sformatf("phase with nothing pending: tdata %h tlast %b",
                                tdata, tlast));
      return;
    end
    want = expected_phases.pop_front();
    if (got.rs !== want.rs)
      report_mismatch($sformatf("reg_select %b, want %b", got.rs, want.rs));
    if (got.rw !== want.rw)
      report_mismatch($sformatf("read_write %b, want %b", got.rw, want.rw));
    if (got.en !== want.en)
      report_mismatch($sformatf("enable_level %b, want %b", got.en, want.en));
    if (got.nib !== want.nib)
      report_mismatch($sformatf("bus_nibble %h, want %h", got.nib, want.nib));
    if (got.hold !== want.hold)
      report_mismatch($sformatf("hold_us %0d, want %0d", got.hold, want.hold));
    if (got.last !== want.last)
      report_mismatch($sformatf("tlast %b, want %b", got.last, want.last));
  endtask

endclass

module tb_char_lcd_nibble_bus_sequencer;

  localparam logic [1:0] OP_UNUSED      = 2'd3;
  localparam int         SETTLE_CYCLES  = 40;
  localparam int         WATCHDOG_LIMIT = 2000;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_valid;
  logic                  s_axis_tready;
  logic [15:0]           s_data;
  logic                  m_axis_tvalid;
  logic                  m_ready;
  logic [23:0]           m_axis_tdata;
  logic                  m_axis_tlast;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  bus_phase_scoreboard sb;
  bit                  tx_gaps_on;
  bit                  rx_stalls_on;
  int                  quiet_cycles;

  char_lcd_nibble_bus_sequencer uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_data),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we),
    .cfg_index_i   (cfg_index),
    .cfg_wdata_i   (cfg_wdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Mostly short gaps, now and then a long one
  function automatic int next_gap(bit enabled);
    int r;
    r = $urandom_range(0, 99);
    if (!enabled || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Receiver side: random back-pressure
  initial begin
    int stall_left;
    stall_left = 0;
    m_ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_left > 0) begin
        m_ready <= 1'b0;
        stall_left--;
      end else begin
        m_ready <= 1'b1;
        if (rx_stalls_on && $urandom_range(0, 3) == 0) begin
          stall_left = next_gap(1'b1);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_ready) begin
      sb.check_phase(m_axis_tdata, m_axis_tlast);
    end
    if ((s_valid && s_axis_tready) || (m_axis_tvalid && m_ready) || cfg_we) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
  end

  initial begin
    quiet_cycles = 0;
    do @(posedge clk_i); while (quiet_cycles < WATCHDOG_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  // Valid stays high after the transfer when no gap follows; the caller
  // either sends again at once or drops it through wait_idle
  task send_item(logic [1:0] op, logic [7:0] b);
    int gap;
    s_valid <= 1'b1;
    s_data  <= {6'b000000, b, op};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_item(op, b);
    gap = next_gap(tx_gaps_on);
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task wait_idle();
    s_valid <= 1'b0;
    while (sb.expected_phases.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task program_timing(logic [15:0] pulse_us, logic [15:0] settle_s_us,
                      logic [15:0] settle_l_us, logic [15:0] wake_wait_us);
    logic [15:0] vals [4];
    wait_idle();
    vals[REG_PULSE_HOLD]   = pulse_us;
    vals[REG_SHORT_SETTLE] = settle_s_us;
    vals[REG_LONG_SETTLE]  = settle_l_us;
    vals[REG_PWR_WAIT]     = wake_wait_us;
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= reg_idx_e'(i);
      cfg_wdata <= vals[i];
      @(posedge clk_i);
    end
    cfg_we <= 1'b0;
    sb.set_timing(pulse_us, settle_s_us, settle_l_us, wake_wait_us);
  endtask

  task run_random(int n_items);
    int          sent;
    int          r;
    logic [1:0]  op;
    logic [7:0]  b;
    sent = 0;
    while (sent < n_items) begin
      // re-pick idling every 25 items so some stretches run flat out
      if (sent % 25 == 0) begin
        tx_gaps_on   = $urandom_range(0, 2) != 0;
        rx_stalls_on = $urandom_range(0, 2) != 0;
      end
      r = $urandom_range(0, 99);
      b = 8'($urandom_range(0, 255));
      if (r < 44) begin
        op = OP_CMD;
        if ($urandom_range(0, 4) == 0) b = $urandom_range(0, 1) ? CMD_CLEAR : CMD_HOME;
      end else if (r < 88) begin
        op = OP_DATA;
      end else if (r < 94) begin
        op = OP_PWR;
      end else begin
        op = OP_UNUSED;
      end
      send_item(op, b);
      sent++;
    end
  endtask

  initial begin
    sb = new();
    tx_gaps_on   = 1'b0;
    rx_stalls_on = 1'b0;
    rst_ni    <= 1'b0;
    s_valid   <= 1'b0;
    s_data    <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= REG_PULSE_HOLD;
    cfg_wdata <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed items on the reset timing
    send_item(OP_CMD, 8'h00);
    send_item(OP_CMD, 8'hFF);
    send_item(OP_CMD, CMD_CLEAR);
    send_item(OP_CMD, CMD_HOME);
    send_item(OP_CMD, 8'h03);
    send_item(OP_DATA, CMD_CLEAR);
    send_item(OP_DATA, CMD_HOME);
    send_item(OP_DATA, 8'h00);
    send_item(OP_DATA, 8'hFF);
    rx_stalls_on = 1'b1;
    send_item(OP_DATA, 8'hA5);
    send_item(OP_CMD, 8'h5A);
    send_item(OP_PWR, 8'h00);
    send_item(OP_PWR, 8'hFF);
    send_item(OP_UNUSED, 8'h37);
    send_item(OP_CMD, CMD_HOME);
    send_item(OP_UNUSED, 8'hC8);
    send_item(OP_UNUSED, 8'h00);
    tx_gaps_on = 1'b1;
    send_item(OP_DATA, 8'h41);
    send_item(OP_CMD, 8'h80);
    send_item(OP_PWR, 8'h5A);

    // Extremes first, then a spread of settings
    program_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_random(75);
    program_timing(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    run_random(75);
    program_timing(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    run_random(75);
    program_timing(16'h0001, 16'hFFFF, 16'h0000, 16'h8000);
    run_random(75);
    program_timing(16'hFF00, 16'h0000, 16'hFFFF, 16'h0001);
    run_random(75);
    program_timing(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    run_random(75);

    wait_idle();
    if (sb.mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
